// ===== hw/rtl/lmql_pkg.sv =====
// lmql_pkg: shared types and constants of the linear model quantile loss block
package lmql_pkg;

	localparam int NUM_COEF  = 4;
	localparam int CFG_IDX_W = 3;
	localparam int DATA_W    = 32;
	localparam int TAU_W     = 16;
	localparam int WEIGHT_W  = 17;
	localparam int TERM_W    = DATA_W + WEIGHT_W;
	localparam int ACC_W     = 63;

	localparam logic [CFG_IDX_W-1:0] CFG_TAU       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = 3'd1;

	localparam logic [TAU_W-1:0]    TAU_RESET = 16'h8000;
	localparam logic [WEIGHT_W-1:0] ONE_Q16   = 17'h10000;

	localparam logic signed [DATA_W-1:0] FIT_MAX = 32'sh7fff_ffff;
	localparam logic signed [DATA_W-1:0] FIT_MIN = 32'sh8000_0000;
	localparam logic [ACC_W-1:0]         ACC_MAX = {ACC_W{1'b1}};

	typedef logic signed [DATA_W-1:0] q16_t;

	typedef struct packed {
		q16_t regressor_0;
		q16_t regressor_1;
		q16_t regressor_2;
		q16_t regressor_3;
		q16_t response;
		logic last_obs;
	} obs_t;

	typedef struct packed {
		logic [ACC_W-1:0] loss_sum;
		logic             saturated;
	} result_t;

	typedef struct packed {
		q16_t fit;
		logic fit_sat;
		q16_t response;
		logic last_obs;
	} fit_t;

endpackage

// ===== hw/rtl/linear_model_quantile_loss.sv =====
// linear_model_quantile_loss: pinball loss of a linear model summed over a data set
//
// observations enter on obs (valid/ready), one beat per observation: four q16.16
// regressors, the response and last_obs. tau and the coefficients are written on
// the cfg channel (index 0 tau, 1..4 coef_0..coef_3, other indexes dropped); cfg
// is always ready; the user must write it only while the block is idle, which
// the block does not enforce. a beat with last_obs set produces one beat on
// result: the q31.32 loss sum and a flag for fit or sum saturation in that set;
// the sum then restarts from zero. throughput is one observation per cycle
// while result is not stalled, set by the accumulator add in the back end. an
// observation passes two front stages (products, fit), the queue, two back
// stages (residual, weighted term) and the accumulator into the result register.
// while result is stalled the back end holds, the queue fills, and obs_ready
// drops once the queue is full and the fit stage holds an observation.
// reset clears the sum, the flag, the queue and all valid bits and loads tau
// to one half and the coefficients to zero.
module linear_model_quantile_loss #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  obs_valid,
	output logic                                  obs_ready,
	input  lmql_pkg::obs_t                        obs,
	output logic                                  result_valid,
	input  logic                                  result_ready,
	output lmql_pkg::result_t                     result,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [lmql_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [lmql_pkg::DATA_W-1:0]           cfg_data
);

	localparam int N = lmql_pkg::NUM_COEF;

	logic [lmql_pkg::TAU_W-1:0]      tau_q;
	lmql_pkg::q16_t [N-1:0]          coef_q;
	logic                            push;
	lmql_pkg::fit_t                  push_data;
	logic                            full;
	logic                            pop;
	logic [$bits(lmql_pkg::fit_t)-1:0] head_bits;
	lmql_pkg::fit_t                  head;
	logic                            head_valid;

	assign cfg_ready = 1'b1;
	assign head      = lmql_pkg::fit_t'(head_bits);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tau_q  <= lmql_pkg::TAU_RESET;
			coef_q <= '0;
		end else if (cfg_valid) begin
			if (cfg_index == lmql_pkg::CFG_TAU) begin
				tau_q <= cfg_data[lmql_pkg::TAU_W-1:0];
			end
			for (int i = 0; i < N; i++) begin
				if (cfg_index == lmql_pkg::CFG_COEF_BASE + lmql_pkg::CFG_IDX_W'(i)) begin
					coef_q[i] <= cfg_data;
				end
			end
		end
	end

	lmql_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs_valid (obs_valid),
		.obs_ready (obs_ready),
		.obs       (obs),
		.coef      (coef_q),
		.push      (push),
		.push_data (push_data),
		.full      (full)
	);

	lmql_fifo #(
		.WIDTH ($bits(lmql_pkg::fit_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_data  (push_data),
		.full       (full),
		.pop        (pop),
		.head       (head_bits),
		.head_valid (head_valid)
	);

	lmql_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.tau          (tau_q),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

// ===== hw/rtl/lmql_fifo.sv =====
// lmql_fifo: small register queue between the fit front end and the loss back end
module lmql_fifo #(
	parameter int WIDTH = 66,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] head,
	output logic             head_valid
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CW'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== hw/rtl/lmql_front.sv =====
// lmql_front: accepts observations and forms the rounded, saturated fit
module lmql_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              obs_valid,
	output logic                              obs_ready,
	input  lmql_pkg::obs_t                    obs,
	input  lmql_pkg::q16_t [lmql_pkg::NUM_COEF-1:0] coef,
	output logic                              push,
	output lmql_pkg::fit_t                    push_data,
	input  logic                              full
);

	localparam int N  = lmql_pkg::NUM_COEF;
	localparam int PW = 2 * lmql_pkg::DATA_W;
	localparam int SW = PW + 1 + $clog2(N);
	localparam int FW = SW - 16;
	localparam int DW = lmql_pkg::DATA_W;

	lmql_pkg::q16_t         x [N];
	logic signed [PW-1:0]   prod_s1 [N];
	lmql_pkg::q16_t         resp_s1;
	logic                   last_s1;
	logic                   valid_s1;
	lmql_pkg::fit_t         fit_s2;
	logic                   valid_s2;
	logic                   en;
	logic signed [SW-1:0]   total;
	logic signed [FW-1:0]   fit_wide;
	logic [FW-DW:0]         fit_hi;
	logic                   fit_over;
	lmql_pkg::q16_t         fit_val;

	assign x[0] = obs.regressor_0;
	assign x[1] = obs.regressor_1;
	assign x[2] = obs.regressor_2;
	assign x[3] = obs.regressor_3;

	assign en        = !valid_s2 || !full;
	assign obs_ready = en;
	assign push      = valid_s2;
	assign push_data = fit_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < N; i++) begin
				prod_s1[i] <= coef[i] * x[i];
			end
			resp_s1 <= obs.response;
			last_s1 <= obs.last_obs;
		end
	end

	// sum of products, round half up to q16.16, clamp to 32 bits
	always_comb begin
		total = SW'(32768);
		for (int i = 0; i < N; i++) begin
			total = total + SW'(prod_s1[i]);
		end
		fit_wide = total[SW-1:16];
		fit_hi   = fit_wide[FW-1:DW-1];
		fit_over = !((&fit_hi) || !(|fit_hi));
		if (fit_over) begin
			fit_val = fit_wide[FW-1] ? lmql_pkg::FIT_MIN : lmql_pkg::FIT_MAX;
		end else begin
			fit_val = fit_wide[DW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fit_s2.fit      <= fit_val;
			fit_s2.fit_sat  <= fit_over;
			fit_s2.response <= resp_s1;
			fit_s2.last_obs <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= obs_valid;
			valid_s2 <= valid_s1;
		end
	end

endmodule

// ===== hw/rtl/lmql_back.sv =====
// lmql_back: residual weighting, loss accumulation and result register
module lmql_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  lmql_pkg::fit_t                    head,
	input  logic                              head_valid,
	output logic                              pop,
	input  logic [lmql_pkg::TAU_W-1:0]        tau,
	output logic                              result_valid,
	input  logic                              result_ready,
	output lmql_pkg::result_t                 result
);

	localparam int DW = lmql_pkg::DATA_W;
	localparam int WW = lmql_pkg::WEIGHT_W;
	localparam int TW = lmql_pkg::TERM_W;
	localparam int AW = lmql_pkg::ACC_W;

	logic signed [DW:0]  resid;
	logic [DW-1:0]       mag_s1;
	logic [WW-1:0]       weight_s1;
	logic                sat_s1;
	logic                last_s1;
	logic                valid_s1;
	logic [TW-1:0]       term_s2;
	logic                sat_s2;
	logic                last_s2;
	logic                valid_s2;
	logic [AW-1:0]       acc_q;
	logic                sat_q;
	lmql_pkg::result_t   result_q;
	logic                result_valid_q;
	logic                en;
	logic [AW:0]         acc_sum;
	logic                acc_over;
	logic [AW-1:0]       acc_next;
	logic                sat_next;

	assign en           = !result_valid_q || result_ready;
	assign pop          = head_valid && en;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	assign resid = {head.response[DW-1], head.response} - {head.fit[DW-1], head.fit};

	always_ff @(posedge clk) begin
		if (en) begin
			if (resid[DW]) begin
				mag_s1    <= DW'(-resid);
				weight_s1 <= lmql_pkg::ONE_Q16 - {1'b0, tau};
			end else begin
				mag_s1    <= resid[DW-1:0];
				weight_s1 <= {1'b0, tau};
			end
			sat_s1  <= head.fit_sat;
			last_s1 <= head.last_obs;
			term_s2 <= mag_s1 * weight_s1;
			sat_s2  <= sat_s1;
			last_s2 <= last_s1;
		end
	end

	always_comb begin
		acc_sum  = {1'b0, acc_q} + (AW + 1)'(term_s2);
		acc_over = acc_sum[AW];
		acc_next = acc_over ? lmql_pkg::ACC_MAX : acc_sum[AW-1:0];
		sat_next = sat_q || sat_s2 || acc_over;
	end

	always_ff @(posedge clk) begin
		if (en && valid_s2 && last_s2) begin
			result_q.loss_sum  <= acc_next;
			result_q.saturated <= sat_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			valid_s2       <= 1'b0;
			acc_q          <= '0;
			sat_q          <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (result_valid_q && result_ready) begin
				result_valid_q <= 1'b0;
			end
			if (en) begin
				valid_s1 <= head_valid;
				valid_s2 <= valid_s1;
				if (valid_s2) begin
					if (last_s2) begin
						acc_q          <= '0;
						sat_q          <= 1'b0;
						result_valid_q <= 1'b1;
					end else begin
						acc_q <= acc_next;
						sat_q <= sat_next;
					end
				end
			end
		end
	end

endmodule

// ===== tb/tb.sv =====
// tb: self-checking testbench for linear_model_quantile_loss, predicts every loss sum beat
`timescale 1ns / 1ps

module tb;

	localparam int LIMIT_CYCLES = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int RAND_PHASES  = 10;
	localparam int PHASE_ITEMS  = 75;
	localparam logic [lmql_pkg::CFG_IDX_W-1:0] CFG_FIRST_UNUSED =
		lmql_pkg::CFG_IDX_W'(lmql_pkg::CFG_COEF_BASE + lmql_pkg::NUM_COEF);

	typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_PATTERN, RX_MOSTLY} rx_mode_e;

	logic                           clk          = 1'b0;
	logic                           arst_n       = 1'b0;
	logic                           obs_valid    = 1'b0;
	lmql_pkg::obs_t                 obs          = '0;
	logic                           result_ready = 1'b0;
	logic                           cfg_valid    = 1'b0;
	logic [lmql_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
	logic [lmql_pkg::DATA_W-1:0]    cfg_data     = '0;
	logic                           obs_ready;
	logic                           result_valid;
	lmql_pkg::result_t              result;
	logic                           cfg_ready;

	logic [lmql_pkg::TAU_W-1:0] tau_model      = lmql_pkg::TAU_RESET;
	lmql_pkg::q16_t             coef_model [lmql_pkg::NUM_COEF] = '{default: '0};
	logic [lmql_pkg::ACC_W-1:0] loss_acc_model = '0;
	logic                       sat_model      = 1'b0;
	lmql_pkg::result_t          expected_sums [$];

	int          fail_count  = 0;
	int          cycle_count = 0;
	int          stall_hold  = 0;
	int          burst_left  = 0;
	int          rx_phase    = 0;
	rx_mode_e    rx_mode     = RX_OPEN;
	logic [31:0] rx_pattern  = '1;

	linear_model_quantile_loss u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.obs_valid    (obs_valid),
		.obs_ready    (obs_ready),
		.obs          (obs),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("linear_model_quantile_loss verification failed");
			$finish;
		end
	end

	function automatic void accumulate_loss(lmql_pkg::obs_t o);
		lmql_pkg::q16_t                x [lmql_pkg::NUM_COEF];
		logic signed [67:0]            dot;
		logic signed [67:0]            a;
		logic signed [67:0]            b;
		logic signed [33:0]            fit;
		logic signed [33:0]            resid;
		logic [33:0]                   mag;
		logic [lmql_pkg::WEIGHT_W-1:0] weight;
		logic [63:0]                   term;
		lmql_pkg::result_t             r;
		x[0] = o.regressor_0;
		x[1] = o.regressor_1;
		x[2] = o.regressor_2;
		x[3] = o.regressor_3;
		dot = '0;
		for (int i = 0; i < lmql_pkg::NUM_COEF; i++) begin
			a = coef_model[i];
			b = x[i];
			dot = dot + a * b;
		end
		// round half up to q16.16
		dot = (dot + 68'sd32768) >>> 16;
		if (dot > lmql_pkg::FIT_MAX) begin
			fit = lmql_pkg::FIT_MAX;
			sat_model = 1'b1;
		end else if (dot < lmql_pkg::FIT_MIN) begin
			fit = lmql_pkg::FIT_MIN;
			sat_model = 1'b1;
		end else begin
			fit = dot[33:0];
		end
		resid = o.response;
		resid = resid - fit;
		if (resid < 0) begin
			mag = -resid;
			weight = lmql_pkg::ONE_Q16 - {1'b0, tau_model};
		end else begin
			mag = resid;
			weight = {1'b0, tau_model};
		end
		term = 64'(mag) * 64'(weight);
		if (term > 64'(lmql_pkg::ACC_MAX) - 64'(loss_acc_model)) begin
			loss_acc_model = lmql_pkg::ACC_MAX;
			sat_model = 1'b1;
		end else begin
			loss_acc_model = loss_acc_model + term[lmql_pkg::ACC_W-1:0];
		end
		if (o.last_obs) begin
			r.loss_sum = loss_acc_model;
			r.saturated = sat_model;
			expected_sums.push_back(r);
			loss_acc_model = '0;
			sat_model = 1'b0;
		end
	endfunction

	always @(posedge clk) begin : monitor
		lmql_pkg::result_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == lmql_pkg::CFG_TAU)
					tau_model = cfg_data[lmql_pkg::TAU_W-1:0];
				else if (cfg_index < CFG_FIRST_UNUSED)
					coef_model[cfg_index - lmql_pkg::CFG_COEF_BASE] = cfg_data;
			end
			if (obs_valid && obs_ready)
				accumulate_loss(obs);
			if (result_valid && result_ready) begin
				if (expected_sums.size() == 0) begin
					fail_count++;
					$display("%0t unexpected result beat: loss_sum %h saturated %b",
						$time, result.loss_sum, result.saturated);
				end else begin
					want = expected_sums.pop_front();
					if (result.loss_sum !== want.loss_sum) begin
						fail_count++;
						$display("%0t loss_sum mismatch: expected %h actual %h",
							$time, want.loss_sum, result.loss_sum);
					end
					if (result.saturated !== want.saturated) begin
						fail_count++;
						$display("%0t saturated mismatch: expected %b actual %b",
							$time, want.saturated, result.saturated);
					end
				end
			end
		end
	end

	always @(negedge clk) begin
		if (stall_hold > 0) begin
			stall_hold--;
			result_ready = 1'b0;
		end else begin
			if (rx_phase == 0) begin
				rx_mode = rx_mode_e'($urandom_range(0, 3));
				rx_pattern = $urandom;
			end
			rx_phase = (rx_phase + 1) % 48;
			case (rx_mode)
				RX_OPEN:    result_ready = 1'b1;
				RX_COIN:    result_ready = 1'($urandom_range(0, 1));
				RX_PATTERN: result_ready = rx_pattern[rx_phase % 32];
				default:    result_ready = ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	function automatic lmql_pkg::q16_t rand_q16(logic wide);
		lmql_pkg::q16_t v;
		case ($urandom_range(0, 9))
			0: v = lmql_pkg::FIT_MAX;
			1: v = lmql_pkg::FIT_MIN;
			2: v = '0;
			3, 4, 5: begin
				v = $urandom_range(0, 32'h0003_ffff);
				v = v - 32'sh0002_0000;
			end
			default: begin
				if (wide) begin
					v = $urandom;
				end else begin
					v = $urandom_range(0, 32'h00ff_ffff);
					v = v - 32'sh0080_0000;
				end
			end
		endcase
		return v;
	endfunction

	function automatic logic [lmql_pkg::DATA_W-1:0] rand_tau_word();
		logic [lmql_pkg::DATA_W-1:0] w;
		w = $urandom;
		case ($urandom_range(0, 5))
			0: w[lmql_pkg::TAU_W-1:0] = '0;
			1: w[lmql_pkg::TAU_W-1:0] = 16'd1;
			2: w[lmql_pkg::TAU_W-1:0] = '1;
			3: w[lmql_pkg::TAU_W-1:0] = lmql_pkg::TAU_RESET;
			default: ;
		endcase
		return w;
	endfunction

	function automatic lmql_pkg::obs_t make_obs(lmql_pkg::q16_t x0, lmql_pkg::q16_t x1,
			lmql_pkg::q16_t x2, lmql_pkg::q16_t x3, lmql_pkg::q16_t y, logic last);
		lmql_pkg::obs_t o;
		o.regressor_0 = x0;
		o.regressor_1 = x1;
		o.regressor_2 = x2;
		o.regressor_3 = x3;
		o.response = y;
		o.last_obs = last;
		return o;
	endfunction

	function automatic lmql_pkg::obs_t rand_obs(logic wide, logic last);
		return make_obs(rand_q16(wide), rand_q16(wide), rand_q16(wide), rand_q16(wide),
			rand_q16(1'b1), last);
	endfunction

	task automatic send_obs(lmql_pkg::obs_t o);
		@(negedge clk);
		obs = o;
		obs_valid = 1'b1;
		@(posedge clk);
		while (!obs_ready) @(posedge clk);
	endtask

	task automatic pause_obs(int n);
		if (n > 0) begin
			@(negedge clk);
			obs_valid = 1'b0;
			obs = rand_obs(1'b1, 1'($urandom_range(0, 1)));
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic offer_obs(lmql_pkg::obs_t o);
		if (burst_left == 0) begin
			pause_obs(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6));
			burst_left = $urandom_range(1, 24);
		end
		burst_left--;
		send_obs(o);
	endtask

	task automatic write_reg(logic [lmql_pkg::CFG_IDX_W-1:0] idx,
			logic [lmql_pkg::DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic program_model(logic [lmql_pkg::DATA_W-1:0] tau_word, lmql_pkg::q16_t c0,
			lmql_pkg::q16_t c1, lmql_pkg::q16_t c2, lmql_pkg::q16_t c3);
		write_reg(lmql_pkg::CFG_TAU, tau_word);
		write_reg(lmql_pkg::CFG_IDX_W'(lmql_pkg::CFG_COEF_BASE + 0), c0);
		write_reg(lmql_pkg::CFG_IDX_W'(lmql_pkg::CFG_COEF_BASE + 1), c1);
		write_reg(lmql_pkg::CFG_IDX_W'(lmql_pkg::CFG_COEF_BASE + 2), c2);
		write_reg(lmql_pkg::CFG_IDX_W'(lmql_pkg::CFG_COEF_BASE + 3), c3);
	endtask

	task automatic settle();
		pause_obs(1);
		while (expected_sums.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		send_obs(make_obs(lmql_pkg::FIT_MAX, lmql_pkg::FIT_MIN, -32'sd1, '0,
			lmql_pkg::FIT_MAX, 1'b0));
		send_obs(make_obs(lmql_pkg::FIT_MIN, lmql_pkg::FIT_MAX, 32'sd1, lmql_pkg::FIT_MAX,
			lmql_pkg::FIT_MIN, 1'b0));
		send_obs(make_obs('0, '0, '0, '0, '0, 1'b1));
		settle();
	endtask

	task automatic test_register_writes();
		program_model(32'hffff_4000, 32'sh0001_0000, -32'sh0000_8000, 32'sh0002_8000,
			-32'sh0003_0000);
		for (int k = CFG_FIRST_UNUSED; k < 2 ** lmql_pkg::CFG_IDX_W; k++)
			write_reg(lmql_pkg::CFG_IDX_W'(k), $urandom);
		send_obs(make_obs(32'sh0001_0000, 32'sh0002_0000, -32'sh0000_4000, 32'sh0000_0001,
			32'sh0005_0000, 1'b0));
		send_obs(make_obs(-32'sh0004_0000, 32'sh0000_8000, 32'sh0001_0000, -32'sh0002_0000,
			-32'sh0007_0000, 1'b1));
		settle();
	endtask

	task automatic test_fit_rounding();
		program_model(lmql_pkg::TAU_RESET, 32'sd1, '0, '0, '0);
		send_obs(make_obs(32'sh0000_8000, '0, '0, '0, '0, 1'b0));
		send_obs(make_obs(-32'sh0000_8000, '0, '0, '0, '0, 1'b0));
		send_obs(make_obs(32'sh0000_7fff, '0, '0, '0, 32'sd1, 1'b0));
		send_obs(make_obs(-32'sh0000_8001, '0, '0, '0, -32'sd1, 1'b1));
		settle();
	endtask

	task automatic test_fit_saturation();
		program_model(lmql_pkg::TAU_RESET, lmql_pkg::FIT_MAX, lmql_pkg::FIT_MIN, '0, '0);
		send_obs(make_obs(lmql_pkg::FIT_MAX, '0, '0, '0, '0, 1'b1));
		send_obs(make_obs(lmql_pkg::FIT_MIN, '0, '0, '0, lmql_pkg::FIT_MAX, 1'b1));
		send_obs(make_obs(32'sd3, 32'sd2, '0, '0, 32'sd7, 1'b1));
		settle();
	endtask

	task automatic test_tau_extremes();
		logic [lmql_pkg::TAU_W-1:0] taus [3];
		taus = '{16'd0, 16'd1, 16'hffff};
		foreach (taus[k]) begin
			program_model({16'h0000, taus[k]}, '0, '0, '0, '0);
			send_obs(make_obs('0, '0, '0, '0, 32'sh0005_0000, 1'b0));
			send_obs(make_obs('0, '0, '0, '0, lmql_pkg::FIT_MIN, 1'b1));
			settle();
		end
	endtask

	task automatic test_random_sets();
		logic wide;
		int   sent;
		int   set_len;
		for (int p = 0; p < RAND_PHASES; p++) begin
			wide = (p % 3 == 0);
			program_model(rand_tau_word(), rand_q16(wide), rand_q16(wide), rand_q16(wide),
				rand_q16(wide));
			if ($urandom_range(0, 2) == 0)
				write_reg(lmql_pkg::CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED,
					2 ** lmql_pkg::CFG_IDX_W - 1)), $urandom);
			sent = 0;
			while (sent < PHASE_ITEMS) begin
				set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
					: $urandom_range(1, 6);
				for (int n = 0; n < set_len; n++)
					offer_obs(rand_obs(wide, n == set_len - 1));
				sent += set_len;
			end
			settle();
		end
	endtask

	task automatic test_backpressure();
		program_model(rand_tau_word(), rand_q16(1'b0), rand_q16(1'b0), rand_q16(1'b0),
			rand_q16(1'b0));
		@(posedge clk);
		stall_hold = 400;
		for (int n = 0; n < 64; n++)
			send_obs(rand_obs(1'b0, (n == 63) || ($urandom_range(0, 1) == 1)));
		settle();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_reset_defaults();
		test_register_writes();
		test_fit_rounding();
		test_fit_saturation();
		test_tau_extremes();
		test_random_sets();
		test_backpressure();
		settle();
		if (expected_sums.size() != 0)
			$display("%0t %0d expected results never arrived", $time, expected_sums.size());
		if (fail_count == 0 && expected_sums.size() == 0)
			$display("linear_model_quantile_loss verification clean");
		else
			$display("linear_model_quantile_loss verification failed");
		$finish;
	end

endmodule

// ===== sim.f =====
hw/rtl/lmql_pkg.sv
hw/rtl/lmql_fifo.sv
hw/rtl/lmql_front.sv
hw/rtl/lmql_back.sv
hw/rtl/linear_model_quantile_loss.sv
tb/tb.sv
